FILE: src/qpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_pkg: shared types and constants
// Table geometry, status codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int TABLE_SIZE = 128;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 64;
  localparam int PAY_W      = 32;
  localparam int STAT_W     = 3;
  localparam int POS_W      = 7;
  localparam int PROBE_STEP = 2;

  // probe sum and step increment width (pos + step may pass the table end)
  localparam int PW         = IDX_W + 2;

  // home slot: byte mod TABLE_SIZE via reciprocal multiply and one correction
  localparam int RECIP_SH   = 16;
  localparam int RECIP      = (1 << RECIP_SH) / TABLE_SIZE;
  localparam int PROD_W     = 8 + RECIP_SH;
  localparam int RW         = IDX_W + 10;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_INSERTED   = 3'd0;
  localparam status_t ST_DROPPED    = 3'd1;
  localparam status_t ST_DELETED    = 3'd2;
  localparam status_t ST_HOME_EMPTY = 3'd3;
  localparam status_t ST_NOT_FOUND  = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef struct packed {
    logic load;     // latch the incoming transaction
    logic calc;     // quotient estimate for the home slot
    logic home;     // home slot resolved, first probe address
    logic probe;    // evaluate the slot at the current probe position
    logic publish;  // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;     // probe finished, result captured
  } dp_sts_t;

endpackage : qpht_pkg
`default_nettype wire

FILE: src/qpht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_ctrl: operation sequencer
// Steps each transaction through home calculation, probing and result hand-off.
// ----------------------------------------------------------------------------
module qpht_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output qpht_pkg::ctrl_cmd_t       cmd,
  input  wire qpht_pkg::dp_sts_t    sts
);
  import qpht_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CALC   = 3'd1;
  localparam logic [2:0] S_HOME   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_HOME;
      end
      S_HOME: begin
        cmd.home  = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.done) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // wait here while the previous result is still unclaimed
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.publish) out_valid_nxt = 1'b1;
    else if (out_ready)       out_valid_nxt = 1'b0;
    else                      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule : qpht_ctrl
`default_nettype wire

FILE: src/qpht_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_dpath: table storage and probe datapath
// Slot memories, used bits, home slot math, probe walk and result registers.
// ----------------------------------------------------------------------------
module qpht_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire qpht_pkg::ctrl_cmd_t         cmd,
  output qpht_pkg::dp_sts_t                sts,
  input  wire logic                        in_operation,
  input  wire logic [qpht_pkg::KEY_W-1:0]  in_key,
  input  wire logic [qpht_pkg::PAY_W-1:0]  in_payload,
  output qpht_pkg::status_t                out_status,
  output logic [qpht_pkg::POS_W-1:0]       out_position
);
  import qpht_pkg::*;

  // slot storage
  logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
  logic [PAY_W-1:0]      pay_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] used_r, used_nxt;
  logic [KEY_W-1:0]      rdata_r;

  // transaction registers
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic [7:0]       q_r;
  logic [IDX_W-1:0] home_r, home_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [PW-1:0]    inc_r, inc_nxt;
  logic             first_r, first_nxt;

  // result registers
  status_t          res_stat_r, res_stat_nxt;
  logic [IDX_W-1:0] res_pos_r, res_pos_nxt;
  status_t          out_stat_r;
  logic [POS_W-1:0] out_pos_r;

  // home slot: byte - q*TABLE_SIZE, q off by at most one
  logic [PROD_W-1:0] prod;
  logic [RW-1:0]     rem0, rem1;

  assign prod = PROD_W'(key_r[7:0]) * PROD_W'(RECIP);

  always_comb begin
    rem0 = RW'(key_r[7:0]) - (RW'(q_r) * RW'(TABLE_SIZE));
    rem1 = (rem0 >= RW'(TABLE_SIZE)) ? rem0 - RW'(TABLE_SIZE) : rem0;
    home_nxt = rem1[IDX_W-1:0];
  end

  // probe evaluation
  logic          used_here, hit, off_end, done;
  logic          slot_wr, slot_clr, advance;
  logic [PW-1:0] sum;

  assign used_here = used_r[pos_r];
  assign hit       = used_here && (rdata_r == key_r);
  assign sum       = PW'(pos_r) + inc_r;
  assign off_end   = (sum >= PW'(TABLE_SIZE));

  always_comb begin
    done         = 1'b0;
    slot_wr      = 1'b0;
    slot_clr     = 1'b0;
    res_stat_nxt = res_stat_r;
    res_pos_nxt  = res_pos_r;
    if (cmd.probe) begin
      unique case (op_r)
        OP_INSERT: begin
          if (!used_here) begin
            done         = 1'b1;
            slot_wr      = 1'b1;
            res_stat_nxt = ST_INSERTED;
            res_pos_nxt  = pos_r;
          end else if (off_end) begin
            done         = 1'b1;
            res_stat_nxt = ST_DROPPED;
            res_pos_nxt  = home_r;
          end
        end
        OP_DELETE: begin
          // empty slots past home are skipped, never compared
          if (first_r && !used_here) begin
            done         = 1'b1;
            res_stat_nxt = ST_HOME_EMPTY;
            res_pos_nxt  = home_r;
          end else if (hit) begin
            done         = 1'b1;
            slot_clr     = 1'b1;
            res_stat_nxt = ST_DELETED;
            res_pos_nxt  = pos_r;
          end else if (off_end) begin
            done         = 1'b1;
            res_stat_nxt = ST_NOT_FOUND;
            res_pos_nxt  = home_r;
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  assign advance  = cmd.probe && !done;
  assign sts.done = done;

  always_comb begin
    pos_nxt   = pos_r;
    inc_nxt   = inc_r;
    first_nxt = first_r;
    if (cmd.home) begin
      pos_nxt   = home_nxt;
      inc_nxt   = PW'(PROBE_STEP);
      first_nxt = 1'b1;
    end else if (advance) begin
      // offsets step*i*i differ by step*(2i+1)
      pos_nxt   = sum[IDX_W-1:0];
      inc_nxt   = inc_r + PW'(2 * PROBE_STEP);
      first_nxt = 1'b0;
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (slot_wr)  used_nxt[pos_r] = 1'b1;
    if (slot_clr) used_nxt[pos_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) used_r <= '0;
    else        used_r <= used_nxt;
  end

  // read address follows the next probe position, so rdata_r matches pos_r
  always_ff @(posedge clk) begin
    if (slot_wr) begin
      key_mem[pos_r] <= key_r;
      pay_mem[pos_r] <= pay_r;
    end
    rdata_r <= key_mem[pos_nxt];
  end

  logic [IDX_W+POS_W-1:0] pos_ext;
  assign pos_ext = {{POS_W{1'b0}}, res_pos_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      key_r <= in_key;
      pay_r <= in_payload;
    end
    if (cmd.calc) q_r <= prod[PROD_W-1:RECIP_SH];
    if (cmd.home) home_r <= home_nxt;
    pos_r      <= pos_nxt;
    inc_r      <= inc_nxt;
    first_r    <= first_nxt;
    res_stat_r <= res_stat_nxt;
    res_pos_r  <= res_pos_nxt;
    if (cmd.publish) begin
      out_stat_r <= res_stat_r;
      out_pos_r  <= pos_ext[POS_W-1:0];
    end
  end

  assign out_status   = out_stat_r;
  assign out_position = out_pos_r;

endmodule : qpht_dpath
`default_nettype wire

FILE: src/quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open addressing table with quadratic probing
// Inserts keyed records or deletes them by key, one transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): in_operation selects insert or delete,
//    in_key is the 64-bit key, in_payload the record stored on insert.
//  - Output channel (out_valid/out_ready): one transaction per input, carrying
//    out_status and out_position (slot used/cleared, or the home slot).
//  - Home slot is the low key byte mod the table size; probes visit
//    home + 2*i*i while inside the table, no wraparound.
//  - Steps: after acceptance, the quotient estimate, the home slot, then one
//    probe per visited slot (1..8 slots at 128 slots), then the load of the
//    output register, which raises out_valid. A new transaction is not taken
//    until the result has been loaded into the output register.
//    The probe walk is bound by the single read port of the key memory.
//  - in_ready is high only while the sequencer is idle. A new transaction is
//    taken while an earlier result still waits in the output register; its
//    own result then holds until the receiver takes the first one.
//  - Reset (rst_n low, synchronous) marks every slot empty at once via the
//    used-bit flops; key and payload memories are not cleared. No sweep.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_operation,
  input  wire logic [qpht_pkg::KEY_W-1:0]  in_key,
  input  wire logic [qpht_pkg::PAY_W-1:0]  in_payload,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [qpht_pkg::STAT_W-1:0]      out_status,
  output logic [qpht_pkg::POS_W-1:0]       out_position
);
  import qpht_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: handshakes and step commands
  qpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage, probe walk and result registers
  qpht_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_payload   (in_payload),
    .out_status   (out_status),
    .out_position (out_position)
  );

endmodule : quadratic_probe_hash_table
`default_nettype wire

FILE: src/qpht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_checker: port-level assertions
// Watches the top-level ports of the hash table over time.
// ----------------------------------------------------------------------------
module qpht_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_operation,
  input wire logic [qpht_pkg::KEY_W-1:0]  in_key,
  input wire logic [qpht_pkg::PAY_W-1:0]  in_payload,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [qpht_pkg::STAT_W-1:0] out_status,
  input wire logic [qpht_pkg::POS_W-1:0]  out_position
);
  import qpht_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_position))
    else $error("result changed while stalled");

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_operation) && $stable(in_key) &&
                              $stable(in_payload))
    else $error("input changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_INSERTED || out_status == ST_DROPPED ||
                   out_status == ST_DELETED || out_status == ST_HOME_EMPTY ||
                   out_status == ST_NOT_FOUND))
    else $error("undefined status code");

  // an accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule : qpht_checker

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .in_key       (in_key),
  .in_payload   (in_payload),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_position (out_position)
);
`default_nettype wire

FILE: bench/tb_quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_table: self-checking bench for the probe hash table
// Drives insert/delete transactions through the valid/ready input channel,
// predicts every status/position with an in-bench table model updated at
// input acceptance, and checks each output transaction in order. Runs a
// directed opener, then random phases with throttling on either side, a
// long receiver hold-off, and a drain between phases.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_table;
  import qpht_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000;  // cycles with no transaction at all
  localparam int RX_HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int RANDOM_OPS     = 630;    // per random phase
  localparam int HOME_POOL_N    = 6;      // homes shared by one phase's keys

  // one pending input transaction
  typedef struct {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } table_op_t;

  // one predicted output transaction
  typedef struct {
    status_t          status;
    logic [POS_W-1:0] position;
  } table_result_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic             in_operation = OP_INSERT;
  logic [KEY_W-1:0] in_key       = '0;
  logic [PAY_W-1:0] in_payload   = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [POS_W-1:0]  out_position;

  quadratic_probe_hash_table dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  table_op_t     pending_ops[$];       // filled by the sequence, drained by driver
  table_result_t expected_results[$];  // pushed at input acceptance, popped by monitor
  int            n_errors    = 0;
  int            tx_idle_pct = 26;
  int            rx_idle_pct = 84;
  int            hold_reqs   = 0;      // bumped to ask the monitor for a hold-off

  // Table shadow. Payload is never returned, so only keys and used bits matter.
  logic [KEY_W-1:0] shadow_key[TABLE_SIZE];
  logic             shadow_used[TABLE_SIZE];

  initial begin
    for (int s = 0; s < TABLE_SIZE; s++) shadow_used[s] = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // Apply one transaction to the shadow table and return what the block
  // should answer. Probe path is home, home+2, home+8, ... below the table
  // end; delete skips empty slots and needs an exact 64-bit key match.
  function automatic void apply_table_op(input logic op, input logic [KEY_W-1:0] key,
                                         output status_t st,
                                         output logic [POS_W-1:0] pos);
    int home;
    int p;
    int i;
    home = int'(key[7:0]) % TABLE_SIZE;
    pos  = home[POS_W-1:0];
    p    = home;
    i    = 0;
    if (op == OP_INSERT) begin
      st = ST_DROPPED;
      while (p < TABLE_SIZE) begin
        if (!shadow_used[p]) begin
          shadow_used[p] = 1'b1;
          shadow_key[p]  = key;
          st             = ST_INSERTED;
          pos            = p[POS_W-1:0];
          return;
        end
        i++;
        p = home + PROBE_STEP * i * i;
      end
    end else begin
      if (!shadow_used[home]) begin
        st = ST_HOME_EMPTY;
        return;
      end
      st = ST_NOT_FOUND;
      while (p < TABLE_SIZE) begin
        if (shadow_used[p] && shadow_key[p] == key) begin
          shadow_used[p] = 1'b0;
          st             = ST_DELETED;
          pos            = p[POS_W-1:0];
          return;
        end
        i++;
        p = home + PROBE_STEP * i * i;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predicts on acceptance, then offers the next queued transaction
  // unless it rolls an idle cycle. Valid and payload stay put until taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : input_driver
    table_op_t     nxt;
    table_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_table_op(in_operation, in_key, res.status, res.position);
        expected_results.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_ops.pop_front();
          in_valid     <= 1'b1;
          in_operation <= nxt.op;
          in_key       <= nxt.key;
          in_payload   <= nxt.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each output transaction against the oldest prediction and
  // throttles out_ready. A hold-off request drops ready for a long stretch so
  // the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin : result_monitor
    table_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d position %0d",
                                    out_status, out_position));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (position %0d)",
                                      out_status, want.status, want.position));
          if (out_position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d (status %0d)",
                                      out_position, want.position, want.status));
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin : stall_watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("quadratic_probe_hash_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence. Runs on the falling edge so queue and handshake state read here
  // are settled.
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0] live_keys[$];   // keys believed stored, for hitting deletes
  logic [7:0]       home_pool[HOME_POOL_N];

  task automatic queue_op(input logic op, input logic [KEY_W-1:0] key,
                          input logic [PAY_W-1:0] payload);
    table_op_t t;
    t.op      = op;
    t.key     = key;
    t.payload = payload;
    pending_ops.push_back(t);
  endtask

  // sender pauses until every queued transaction is taken and answered
  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pool_key();
    logic [KEY_W-1:0] k;
    k      = {$urandom(), $urandom()};
    k[7:0] = home_pool[$urandom_range(HOME_POOL_N - 1)];
    return k;
  endfunction

  // Mostly insert/delete churn over a few shared homes so probe chains grow
  // deep, fill up and drop; the rest is duplicates, misses and noise.
  task automatic queue_random_ops(input int count);
    int               r;
    int               idx;
    logic [KEY_W-1:0] k;
    // one home near the table end so short probe paths overflow quickly
    home_pool[0] = 8'(120 + $urandom_range(7)) | ($urandom_range(1) ? 8'h80 : 8'h00);
    for (int h = 1; h < HOME_POOL_N; h++) home_pool[h] = 8'($urandom_range(255));
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        queue_op(1'($urandom_range(1)), {$urandom(), $urandom()}, $urandom());
      end else if (r < 48 || live_keys.size() == 0) begin
        k = pool_key();
        live_keys.push_back(k);
        queue_op(OP_INSERT, k, $urandom());
      end else if (r < 53) begin
        k = live_keys[$urandom_range(live_keys.size() - 1)];
        queue_op(OP_INSERT, k, $urandom());
      end else if (r < 88) begin
        idx = $urandom_range(live_keys.size() - 1);
        k   = live_keys[idx];
        live_keys.delete(idx);
        queue_op(OP_DELETE, k, $urandom());
      end else begin
        queue_op(OP_DELETE, pool_key(), $urandom());
      end
    end
  endtask

  initial begin : test_sequence
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opener
    queue_op(OP_DELETE, 64'h0, 32'h0);                       // empty table
    queue_op(OP_INSERT, 64'h0, 32'h0);                       // lands on home 0
    queue_op(OP_INSERT, '1, '1);                             // byte 0xFF -> home 127
    queue_op(OP_INSERT, 64'h5A5A_0000_0000_007F, 32'hA5A5_5A5A); // 127 full, no probe left
    queue_op(OP_DELETE, 64'h8000_0000_0000_0000, '1);        // top bit differs: not found
    queue_op(OP_INSERT, 64'h80, 32'h1234_5678);              // 0x80 folds to home 0, slot 2
    queue_op(OP_INSERT, 64'h0, 32'h1);                       // duplicate goes to slot 8
    queue_op(OP_DELETE, 64'h0, 32'h0);                       // hit at home
    queue_op(OP_DELETE, 64'h0, 32'h0);                       // no tombstone: home empty
    queue_op(OP_INSERT, 64'h0, 32'h2);
    queue_op(OP_DELETE, 64'h80, 32'h0);                      // hit on first probe
    for (int i = 1; i <= 9; i++)                             // walk home 0 path to the end
      queue_op(OP_INSERT, {56'(i), 8'h00}, 32'(i));
    queue_op(OP_DELETE, {56'(6), 8'h00}, 32'h0);             // deepest slot on the path
    queue_op(OP_DELETE, '1, 32'h0);
    queue_op(OP_DELETE, 64'h5A5A_0000_0000_007F, 32'h0);
    wait_drained();

    // sender light idling, receiver heavy back-pressure
    queue_random_ops(RANDOM_OPS);
    wait_drained();

    tx_idle_pct = 84;
    rx_idle_pct = 26;
    queue_random_ops(RANDOM_OPS);
    wait_drained();

    // full rate, opened by a long receiver hold-off while items keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    queue_random_ops(RANDOM_OPS);
    wait_drained();

    repeat (20) @(negedge clk);
    if (n_errors == 0)
      $display("quadratic_probe_hash_table test passed");
    else
      $display("quadratic_probe_hash_table test failed");
    $finish;
  end

endmodule
